// File: hw/rtl/cfsc_pkg.sv
// ----------------------------------------------------------------------------
// Chunk frequency stream classifier package
// Shared sizes, constants and handshake structs for the classifier modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cfsc_pkg;

  // Chunk geometry.
  localparam int CHUNK_MB          = 1;
  localparam int CHUNK_ENTRIES     = 4096;
  localparam int SECTOR_BYTES      = 512;
  localparam int BYTES_PER_MB      = 1024 * 1024;
  localparam int SECTORS_PER_CHUNK = CHUNK_MB * BYTES_PER_MB / SECTOR_BYTES;
  localparam int CHUNK_SHIFT       = $clog2(SECTORS_PER_CHUNK);
  localparam int SLOT_W            = $clog2(CHUNK_ENTRIES);

  // Field widths.
  localparam int ADDR_W   = 23;
  localparam int SC_W     = 5;
  localparam int STREAM_W = 5;

  // Hit counters.
  localparam int HIT_BITS = 24;
  localparam logic [HIT_BITS-1:0] HIT_MAX = '1;

  // One table entry holds the valid bit over the hit counter.
  localparam int ENTRY_W = HIT_BITS + 1;

  // Reset value of the stream count register.
  localparam logic [SC_W-1:0] SC_RESET = SC_W'(4);

  // Divider sizes: the dividend may be one bit wider than a counter.
  localparam int DIVIDEND_W = HIT_BITS + 1;
  localparam int DIV_STEPS  = DIVIDEND_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  // Request to the shared divider.
  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [HIT_BITS-1:0]   divisor;
  } div_req_t;

  // Response from the shared divider.
  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/cfsc_ram.sv
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module cfsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/cfsc_div.sv
// ----------------------------------------------------------------------------
// Bit-serial unsigned divider
// Restoring division, one quotient bit per cycle, shared by both divisions.
// ----------------------------------------------------------------------------
`default_nettype none

module cfsc_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cfsc_pkg::div_req_t req,
  output cfsc_pkg::div_rsp_t      rsp
);

  logic [cfsc_pkg::HIT_BITS-1:0]   rem;
  logic [cfsc_pkg::DIVIDEND_W-1:0] quo;
  logic [cfsc_pkg::HIT_BITS-1:0]   dvs;
  logic [cfsc_pkg::DIV_CNT_W-1:0]  cnt;
  logic                            active;
  logic                            done;

  logic [cfsc_pkg::DIVIDEND_W-1:0] shifted;
  logic [cfsc_pkg::DIVIDEND_W-1:0] diff;
  logic                            ge;

  // One trial subtraction of the partial remainder.
  always_comb begin
    shifted = {rem, quo[cfsc_pkg::DIVIDEND_W-1]};
    ge      = shifted >= {1'b0, dvs};
    diff    = shifted - {1'b0, dvs};
  end

  // Iteration control and datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        active <= 1'b1;
        cnt    <= cfsc_pkg::DIV_CNT_W'(cfsc_pkg::DIV_STEPS);
        rem    <= '0;
        quo    <= req.dividend;
        dvs    <= req.divisor;
      end else if (active) begin
        rem <= ge ? diff[cfsc_pkg::HIT_BITS-1:0] : shifted[cfsc_pkg::HIT_BITS-1:0];
        quo <= {quo[cfsc_pkg::DIVIDEND_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == cfsc_pkg::DIV_CNT_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

// File: hw/rtl/chunk_frequency_stream_classifier_top.sv
// ----------------------------------------------------------------------------
// Chunk frequency stream classifier
// Maps each write item's sector address to a write stream by chunk hotness.
// ----------------------------------------------------------------------------
// After reset the block sweeps its 4096-entry chunk table to zero with busy
// high; stream_count writes are taken during the sweep as well.
// An item is taken when start is high and busy is low, and busy stays high
// until its result is out. The first item to a chunk goes through accept,
// table read-modify-write and result. A repeat hit has the table update,
// then two passes through one bit-serial divider (peak count over stream
// count, then the rounded-up stream quotient). When the peak count is below
// the stream count the second pass is skipped. The result is shown for
// exactly one cycle with done high; the receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module chunk_frequency_stream_classifier_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [cfsc_pkg::SC_W-1:0]     cfg_wdata,
  input  wire logic                          start,
  input  wire logic [cfsc_pkg::ADDR_W-1:0]   sector_address,
  output logic                               busy,
  output logic                               done,
  output logic      [cfsc_pkg::STREAM_W-1:0] stream_number,
  output logic                               first_touch
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_DIV1,
    ST_DIV2
  } state_t;

  state_t                            state;
  logic [cfsc_pkg::SLOT_W-1:0]       clear_addr;
  logic [cfsc_pkg::SLOT_W-1:0]       slot;
  logic [cfsc_pkg::SC_W-1:0]         stream_count;
  logic [cfsc_pkg::SC_W-1:0]         sc_lat;
  logic [cfsc_pkg::HIT_BITS-1:0]     peak;
  logic [cfsc_pkg::HIT_BITS-1:0]     count;

  logic [cfsc_pkg::ADDR_W-1:0]       addr_shifted;
  logic [cfsc_pkg::SLOT_W-1:0]       in_slot;
  logic [cfsc_pkg::SC_W-1:0]         sc_eff;
  logic                              accept;

  logic                              ram_we;
  logic [cfsc_pkg::SLOT_W-1:0]       ram_waddr;
  logic [cfsc_pkg::ENTRY_W-1:0]      ram_wdata;
  logic [cfsc_pkg::SLOT_W-1:0]       ram_raddr;
  logic [cfsc_pkg::ENTRY_W-1:0]      ram_rdata;

  logic                              entry_valid;
  logic [cfsc_pkg::HIT_BITS-1:0]     entry_hits;
  logic [cfsc_pkg::HIT_BITS-1:0]     count_next;
  logic [cfsc_pkg::HIT_BITS-1:0]     peak_next;
  logic [cfsc_pkg::DIVIDEND_W-1:0]   round_dividend;

  cfsc_pkg::div_req_t                div_req;
  cfsc_pkg::div_rsp_t                div_rsp;

  // Chunk index from the sector address, wrapped to the table size.
  assign addr_shifted = sector_address >> cfsc_pkg::CHUNK_SHIFT;
  assign in_slot      = addr_shifted[cfsc_pkg::SLOT_W-1:0];

  // A stream count of zero acts as one.
  assign sc_eff = (stream_count == '0) ? cfsc_pkg::SC_W'(1) : stream_count;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // Decode the entry read back from the table and form the updated counts.
  // The rounding dividend takes the share straight from the divider output.
  always_comb begin
    entry_valid    = ram_rdata[cfsc_pkg::HIT_BITS];
    entry_hits     = ram_rdata[cfsc_pkg::HIT_BITS-1:0];
    count_next     = (entry_hits == cfsc_pkg::HIT_MAX) ? entry_hits : entry_hits + 1'b1;
    peak_next      = (count_next > peak) ? count_next : peak;
    round_dividend = {1'b0, count} + div_rsp.quotient - cfsc_pkg::DIVIDEND_W'(1);
  end

  // Table port control: the clearing sweep, then one write-back per item.
  always_comb begin
    ram_raddr = (state == ST_IDLE) ? in_slot : slot;
    ram_we    = 1'b0;
    ram_waddr = slot;
    ram_wdata = '0;
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clear_addr;
    end else if (state == ST_EVAL) begin
      ram_we    = 1'b1;
      ram_wdata = entry_valid ? {1'b1, count_next} : {1'b1, {cfsc_pkg::HIT_BITS{1'b0}}};
    end
  end

  // Divider requests: the share first, then the rounded-up stream quotient.
  always_comb begin
    div_req = '0;
    if (state == ST_EVAL && entry_valid) begin
      div_req.start    = 1'b1;
      div_req.dividend = {1'b0, peak_next};
      div_req.divisor  = cfsc_pkg::HIT_BITS'(sc_lat);
    end else if (state == ST_DIV1 && div_rsp.done &&
                 div_rsp.quotient != '0) begin
      div_req.start    = 1'b1;
      div_req.dividend = round_dividend;
      div_req.divisor  = div_rsp.quotient[cfsc_pkg::HIT_BITS-1:0];
    end
  end

  // Sequencer, counters and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clear_addr   <= '0;
      stream_count <= cfsc_pkg::SC_RESET;
      sc_lat       <= cfsc_pkg::SC_RESET;
      peak         <= '0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        stream_count <= cfg_wdata;
      end
      unique case (state)
        ST_CLEAR: begin
          clear_addr <= clear_addr + 1'b1;
          if (clear_addr == cfsc_pkg::SLOT_W'(cfsc_pkg::CHUNK_ENTRIES - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            slot   <= in_slot;
            sc_lat <= sc_eff;
            state  <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (!entry_valid) begin
            if (peak == '0) begin
              peak <= cfsc_pkg::HIT_BITS'(1);
            end
            stream_number <= cfsc_pkg::STREAM_W'(1);
            first_touch   <= 1'b1;
            done          <= 1'b1;
            state         <= ST_IDLE;
          end else begin
            count <= count_next;
            peak  <= peak_next;
            state <= ST_DIV1;
          end
        end
        ST_DIV1: begin
          if (div_rsp.done) begin
            if (div_rsp.quotient == '0) begin
              stream_number <= cfsc_pkg::STREAM_W'(1);
              first_touch   <= 1'b0;
              done          <= 1'b1;
              state         <= ST_IDLE;
            end else begin
              state <= ST_DIV2;
            end
          end
        end
        ST_DIV2: begin
          if (div_rsp.done) begin
            if (div_rsp.quotient > cfsc_pkg::DIVIDEND_W'(sc_lat)) begin
              stream_number <= sc_lat;
            end else begin
              stream_number <= div_rsp.quotient[cfsc_pkg::STREAM_W-1:0];
            end
            first_touch <= 1'b0;
            done        <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Chunk table: valid bit and hit counter per chunk.
  cfsc_ram #(
    .WIDTH(cfsc_pkg::ENTRY_W),
    .DEPTH(cfsc_pkg::CHUNK_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Shared divider.
  cfsc_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  // A result leaves the block idle and ready for the next item.
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while still busy");

  // Every stream lies between one and the latched stream count.
  assert property (@(posedge clk) disable iff (rst)
    done |-> (stream_number != '0) && (stream_number <= sc_lat))
    else $error("stream number out of range");

  // A first touch always goes to the coldest stream.
  assert property (@(posedge clk) disable iff (rst)
    done && first_touch |-> stream_number == cfsc_pkg::STREAM_W'(1))
    else $error("first touch not on stream one");

  // The peak count never falls outside reset.
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> peak >= $past(peak))
    else $error("peak count decreased");

endmodule

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunk frequency stream classifier testbench
// Drives write items into the classifier, tracks chunk hotness in a local
// scoreboard and checks every stream assignment as it is strobed out. A short
// directed run covers the address extremes and the first and repeat hits.
// Random phases follow, one per stream count setting, with bursty traffic
// focused on a pool of hot chunks.
// ----------------------------------------------------------------------------

module testbench;

  localparam int CLK_HALF    = 4;
  localparam int CYCLE_LIMIT = 600000;
  localparam int ITEMS_PER_PHASE = 148;
  localparam int HOT_POOL    = 16;

  // One expected classifier result.
  typedef struct {
    logic [cfsc_pkg::STREAM_W-1:0] stream_number;
    logic                          first_touch;
  } stream_result_t;

  // Tracks per-chunk hit counts and the peak count, predicts the stream of
  // each accepted item and checks the strobed results in order.
  class chunk_heat_tracker;
    bit                            chunk_seen  [cfsc_pkg::CHUNK_ENTRIES];
    logic [cfsc_pkg::HIT_BITS-1:0] chunk_count [cfsc_pkg::CHUNK_ENTRIES];
    logic [cfsc_pkg::HIT_BITS-1:0] peak_count;
    logic [cfsc_pkg::SC_W-1:0]     stream_total;
    stream_result_t                pending_streams[$];
    int                            mismatches;

    function new();
      foreach (chunk_seen[i]) chunk_seen[i] = 1'b0;
      peak_count   = '0;
      stream_total = cfsc_pkg::SC_RESET;
      mismatches   = 0;
    endfunction

    function void set_stream_total(logic [cfsc_pkg::SC_W-1:0] value);
      stream_total = value;
    endfunction

    function void note_request(logic [cfsc_pkg::ADDR_W-1:0] addr);
      int unsigned     slot;
      longint unsigned spread;
      longint unsigned count;
      longint unsigned share;
      longint unsigned stream;
      stream_result_t  res;
      slot   = (int'(addr) >> cfsc_pkg::CHUNK_SHIFT) % cfsc_pkg::CHUNK_ENTRIES;
      spread = (stream_total == 0) ? 1 : stream_total;
      if (!chunk_seen[slot]) begin
        // A new chunk starts cold.
        chunk_seen[slot]  = 1'b1;
        chunk_count[slot] = '0;
        if (peak_count == 0) peak_count = 1;
        res.stream_number = cfsc_pkg::STREAM_W'(1);
        res.first_touch   = 1'b1;
      end else begin
        // A repeat hit bumps the saturating counter and rescales the stream.
        count = chunk_count[slot];
        if (count < cfsc_pkg::HIT_MAX) count++;
        chunk_count[slot] = cfsc_pkg::HIT_BITS'(count);
        if (count > peak_count) peak_count = cfsc_pkg::HIT_BITS'(count);
        share = peak_count / spread;
        if (share == 0) stream = 1;
        else stream = (count + share - 1) / share;
        if (stream > spread) stream = spread;
        res.stream_number = cfsc_pkg::STREAM_W'(stream);
        res.first_touch   = 1'b0;
      end
      pending_streams.push_back(res);
    endfunction

    function void check_result(logic [cfsc_pkg::STREAM_W-1:0] stream_number,
                               logic first_touch);
      stream_result_t want;
      if (pending_streams.size() == 0) begin
        if (mismatches < 10)
          $display("Unexpected result: stream %0d first_touch %0b", stream_number, first_touch);
        mismatches++;
        return;
      end
      want = pending_streams.pop_front();
      if (want.stream_number !== stream_number || want.first_touch !== first_touch) begin
        if (mismatches < 10)
          $display("Mismatch: expected stream %0d first_touch %0b, got stream %0d first_touch %0b",
                   want.stream_number, want.first_touch, stream_number, first_touch);
        mismatches++;
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic [cfsc_pkg::SC_W-1:0]     cfg_wdata;
  logic                          start;
  logic [cfsc_pkg::ADDR_W-1:0]   sector_address;
  logic                          busy;
  logic                          done;
  logic [cfsc_pkg::STREAM_W-1:0] stream_number;
  logic                          first_touch;

  chunk_heat_tracker   tracker;
  int                  cycle_count;
  int unsigned         hot_slots [HOT_POOL];

  chunk_frequency_stream_classifier_top dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .start          (start),
    .sector_address (sector_address),
    .busy           (busy),
    .done           (done),
    .stream_number  (stream_number),
    .first_touch    (first_touch)
  );

  // Free-running clock.
  always #CLK_HALF clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Check strobed results and record accepted items at each edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) tracker.check_result(stream_number, first_touch);
      if (start && !busy) tracker.note_request(sector_address);
    end
  end

  // Presents one item and returns right after the edge that accepts it.
  task automatic send_request(logic [cfsc_pkg::ADDR_W-1:0] addr);
    start          <= 1'b1;
    sector_address <= addr;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  // Drops start and waits out a gap; only called with a nonzero length.
  task automatic hold_off(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Drops start and waits until every expected result has arrived.
  task automatic drain_results();
    start <= 1'b0;
    do @(negedge clk); while (tracker.pending_streams.size() != 0 || busy);
    @(posedge clk);
  endtask

  // Writes the stream count while the block is idle.
  task automatic write_stream_total(logic [cfsc_pkg::SC_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tracker.set_stream_total(value);
  endtask

  // Mostly hot-pool chunks with a skew toward the first entries, plus some
  // scattered and boundary addresses.
  function automatic logic [cfsc_pkg::ADDR_W-1:0] pick_address();
    int unsigned choice;
    int unsigned slot;
    int unsigned offset;
    choice = $urandom_range(0, 99);
    if (choice < 12) return cfsc_pkg::ADDR_W'($urandom);
    if (choice < 80) slot = hot_slots[$urandom_range(0, $urandom_range(0, HOT_POOL - 1))];
    else slot = hot_slots[$urandom_range(0, HOT_POOL - 1)];
    case ($urandom_range(0, 5))
      0:       offset = 0;
      1:       offset = cfsc_pkg::SECTORS_PER_CHUNK - 1;
      default: offset = $urandom_range(0, cfsc_pkg::SECTORS_PER_CHUNK - 1);
    endcase
    return cfsc_pkg::ADDR_W'((slot << cfsc_pkg::CHUNK_SHIFT) | offset);
  endfunction

  // One random phase of bursty traffic.
  task automatic run_phase(int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && sent < count; i++) begin
        send_request(pick_address());
        sent++;
      end
      // Some bursts run straight into the next one.
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 64));
    end
    drain_results();
  endtask

  initial begin
    logic [cfsc_pkg::SC_W-1:0] phase_totals [7];
    clk            = 1'b0;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    start          = 1'b0;
    sector_address = '0;
    cycle_count    = 0;
    tracker        = new();
    foreach (hot_slots[i]) hot_slots[i] = $urandom_range(0, cfsc_pkg::CHUNK_ENTRIES - 1);
    hot_slots[0] = 0;
    hot_slots[1] = cfsc_pkg::CHUNK_ENTRIES - 1;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset stream count, first and repeat hits, address extremes.
    send_request(cfsc_pkg::ADDR_W'(0));
    send_request(cfsc_pkg::ADDR_W'(0));
    send_request('1);
    send_request('1);
    send_request(cfsc_pkg::ADDR_W'(cfsc_pkg::SECTORS_PER_CHUNK - 1));
    send_request(cfsc_pkg::ADDR_W'(cfsc_pkg::SECTORS_PER_CHUNK - 1));
    send_request(cfsc_pkg::ADDR_W'(cfsc_pkg::SECTORS_PER_CHUNK - 1));
    send_request(cfsc_pkg::ADDR_W'(cfsc_pkg::SECTORS_PER_CHUNK - 1));
    send_request(cfsc_pkg::ADDR_W'(cfsc_pkg::SECTORS_PER_CHUNK));
    send_request(cfsc_pkg::ADDR_W'(cfsc_pkg::SECTORS_PER_CHUNK));
    send_request(cfsc_pkg::ADDR_W'(23'h7FF800));
    send_request(cfsc_pkg::ADDR_W'(23'h400000));
    send_request(cfsc_pkg::ADDR_W'(23'h3FFFFF));
    send_request(cfsc_pkg::ADDR_W'(23'h555555));
    send_request(cfsc_pkg::ADDR_W'(23'h2AAAAA));
    send_request(cfsc_pkg::ADDR_W'(23'h2AAAAA));
    drain_results();

    // Directed: largest register value, then zero which acts as one.
    write_stream_total(cfsc_pkg::SC_W'(31));
    send_request(cfsc_pkg::ADDR_W'(0));
    send_request('1);
    send_request(cfsc_pkg::ADDR_W'(23'h555555));
    drain_results();
    write_stream_total(cfsc_pkg::SC_W'(0));
    send_request(cfsc_pkg::ADDR_W'(0));
    send_request(cfsc_pkg::ADDR_W'(cfsc_pkg::SECTORS_PER_CHUNK));
    send_request(cfsc_pkg::ADDR_W'(23'h100000));
    drain_results();

    // Random phases over several stream counts, extremes included.
    phase_totals = '{cfsc_pkg::SC_W'(16), cfsc_pkg::SC_W'(1), cfsc_pkg::SC_W'(0),
                     cfsc_pkg::SC_W'(31), cfsc_pkg::SC_W'(7),
                     cfsc_pkg::SC_W'($urandom_range(2, 30)), cfsc_pkg::SC_W'(4)};
    foreach (phase_totals[p]) begin
      write_stream_total(phase_totals[p]);
      for (int i = HOT_POOL / 2; i < HOT_POOL; i++)
        hot_slots[i] = $urandom_range(0, cfsc_pkg::CHUNK_ENTRIES - 1);
      run_phase(ITEMS_PER_PHASE);
    end

    // Let any stray strobe show up before the verdict.
    repeat (64) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_streams.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
